// ===== rtl/grid_ray_march_column_macros.svh =====
// ----------------------------------------------------------------------------
// Ray march column caster: assertion macros
// Implication and next-cycle checks, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_MARCH_COLUMN_MACROS_SVH
`define GRID_RAY_MARCH_COLUMN_MACROS_SVH
`ifndef SYNTH
`define GRM_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: implication check failed");
`define GRM_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: next-cycle check failed");
`else
`define GRM_ASSERT_IMP(lbl, clk, rst, pre, post)
`define GRM_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== rtl/grm_pkg.sv =====
// ----------------------------------------------------------------------------
// grm_pkg
// Shared constants, types and tables of the ray march column caster.
// ----------------------------------------------------------------------------
package grm_pkg;

   localparam int CORDIC_STEPS = 14;
   localparam int CORDIC_IW    = 4;
   localparam int CORDIC_GAIN  = 9949;
   localparam int TRIG_ONE     = 16384;
   localparam int ANG_W        = 16;
   localparam int TRIG_W       = 16;
   localparam int POS_SHIFT    = 14;
   localparam int CELL_SHIFT   = 22;
   localparam int CORR_SHIFT   = 28;
   localparam int DIST_W       = 13;
   localparam int DIST_MAX     = 8191;
   localparam int MUL_W        = 32;
   localparam int MUL_CW       = 5;
   localparam int SQ_W         = 64;
   localparam int SQ_CW        = 5;
   localparam int DIV_NW       = 24;
   localparam int DIV_DW       = 16;
   localparam int DIV_CW       = 5;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CAST = 1'b1;

   localparam logic [1:0] CSR_FOV  = 2'd0;
   localparam logic [1:0] CSR_STEP = 2'd1;
   localparam logic [1:0] CSR_FAR  = 2'd2;
   localparam logic [1:0] CSR_MIN  = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic [13:0] atan_lookup(input logic [CORDIC_IW-1:0] idx);
      logic [13:0] v;
      case (idx)
         4'd0:    v = 14'd8192;
         4'd1:    v = 14'd4836;
         4'd2:    v = 14'd2555;
         4'd3:    v = 14'd1297;
         4'd4:    v = 14'd651;
         4'd5:    v = 14'd326;
         4'd6:    v = 14'd163;
         4'd7:    v = 14'd81;
         4'd8:    v = 14'd41;
         4'd9:    v = 14'd20;
         4'd10:   v = 14'd10;
         4'd11:   v = 14'd5;
         4'd12:   v = 14'd3;
         4'd13:   v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [18:0] v);
      logic signed [TRIG_W-1:0] r;
      if (v > 19'sd16384)
         r = 16'sd16384;
      else if (v < -19'sd16384)
         r = -16'sd16384;
      else
         r = v[TRIG_W-1:0];
      return r;
   endfunction

endpackage

// ===== rtl/grm_cordic.sv =====
// ----------------------------------------------------------------------------
// grm_cordic
// Rotation CORDIC, one micro-rotation a cycle, quadrant folded at the end.
// ----------------------------------------------------------------------------
module grm_cordic
   import grm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ANG_W-1:0]         angle,
   output unit_stat_type            stat,
   output logic signed [TRIG_W-1:0] cos_out,
   output logic signed [TRIG_W-1:0] sin_out
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CORDIC_IW-1:0]     iter_ff, iter_in;
   logic signed [17:0]       x_ff, x_in, y_ff, y_in;
   logic signed [16:0]       z_ff, z_in;
   logic [1:0]               quad_ff, quad_in;
   logic signed [TRIG_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [17:0]       xs, ys;
   logic signed [16:0]       at;
   logic signed [18:0]       xe, ye;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      xs      = x_ff >>> iter_ff;
      ys      = y_ff >>> iter_ff;
      at      = $signed({3'b000, atan_lookup(iter_ff)});
      xe      = '0;
      ye      = '0;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         x_in    = 18'(CORDIC_GAIN);
         y_in    = '0;
         z_in    = $signed({3'b000, angle[13:0]});
         quad_in = angle[15:14];
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == CORDIC_IW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            xe      = {x_in[17], x_in};
            ye      = {y_in[17], y_in};
            case (quad_ff)
               2'd0: begin
                  cos_in = clamp_trig(xe);
                  sin_in = clamp_trig(ye);
               end
               2'd1: begin
                  cos_in = clamp_trig(-ye);
                  sin_in = clamp_trig(xe);
               end
               2'd2: begin
                  cos_in = clamp_trig(-xe);
                  sin_in = clamp_trig(-ye);
               end
               default: begin
                  cos_in = clamp_trig(ye);
                  sin_in = clamp_trig(-xe);
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;

endmodule

// ===== rtl/grm_mul.sv =====
// ----------------------------------------------------------------------------
// grm_mul
// Unsigned shift-add multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module grm_mul
   import grm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_W-1:0]   a,
   input  logic [MUL_W-1:0]   b,
   output unit_stat_type      stat,
   output logic [2*MUL_W-1:0] prod
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CW-1:0]    cnt_ff, cnt_in;
   logic [2*MUL_W-1:0]   acc_ff, acc_in, a_ff, a_in;
   logic [MUL_W-1:0]     b_ff, b_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = (2*MUL_W)'(a);
         b_in    = b;
      end else if (busy_ff) begin
         if (b_ff[0])
            acc_in = acc_ff + a_ff;
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CW'(MUL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod      = acc_ff;

endmodule

// ===== rtl/grm_sqrt.sv =====
// ----------------------------------------------------------------------------
// grm_sqrt
// Floor square root, digit by digit, one result bit a cycle.
// ----------------------------------------------------------------------------
module grm_sqrt
   import grm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   val,
   output unit_stat_type     stat,
   output logic [SQ_W/2-1:0] root
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SQ_CW-1:0]  cnt_ff, cnt_in;
   logic [SQ_W-1:0]   v_ff, v_in, r_ff, r_in;
   logic [SQ_W-1:0]   bit_v, trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_v   = {2'b01, {(SQ_W-2){1'b0}}} >> {cnt_ff, 1'b0};
      trial   = r_ff + bit_v;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         v_in    = val;
         r_in    = '0;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_v;
         end else begin
            r_in = r_ff >> 1;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CW'(SQ_W/2 - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      v_ff   <= v_in;
      r_ff   <= r_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = r_ff[SQ_W/2-1:0];

endmodule

// ===== rtl/grm_div.sv =====
// ----------------------------------------------------------------------------
// grm_div
// Restoring unsigned divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module grm_div
   import grm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] num,
   input  logic [DIV_DW-1:0] den,
   output unit_stat_type     stat,
   output logic [DIV_NW-1:0] quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DIV_NW-1:0] q_ff, q_in;
   logic [DIV_DW:0]   sh;
   logic              ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      sh      = {rem_ff, q_ff[DIV_NW-1]};
      ge      = sh >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         q_in    = num;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor
         rem_in = ge ? DIV_DW'(sh - {1'b0, den_ff}) : sh[DIV_DW-1:0];
         q_in   = {q_ff[DIV_NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

endmodule

// ===== rtl/grid_ray_march_column.sv =====
// A cast word is answered on rsp_valid after its march steps; each march step is a map
// row read, then a wall test and advance.
// Iterations per shared-unit pass: multiplier 32, square root 32, divider 24, CORDIC 14.
// A cosine <= 0 skips the correction, and a wall at or beyond far skips the three
// divides. One word at a time; a load word is taken while idle and leaves the caster
// idle. Reset restores register defaults and marks every map row empty at once.
// ----------------------------------------------------------------------------
// grid_ray_march_column
// Fixed-step grid ray caster: one wall column result per cast word.
// ----------------------------------------------------------------------------
`include "grid_ray_march_column_macros.svh"

module grid_ray_march_column
   import grm_pkg::*;
#(
   parameter int MAP_DIM      = 16,
   parameter int COLUMNS      = 80,
   parameter int SCREEN_ROWS  = 24,
   parameter int SHADE_LEVELS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [3:0]  req_map_row,
   input  logic [15:0] req_row_bits,
   input  logic [11:0] req_pos_x,
   input  logic [11:0] req_pos_y,
   input  logic [15:0] req_view_angle,
   input  logic [6:0]  req_column,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_column_out,
   output logic [12:0] rsp_wall_distance,
   output logic [4:0]  rsp_wall_top,
   output logic [4:0]  rsp_wall_end,
   output logic [3:0]  rsp_shade_index,
   output logic [7:0]  rsp_wall_brightness,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int RW = (MAP_DIM > 1) ? $clog2(MAP_DIM) : 1;
   localparam int CW = ((RW > 4) ? RW : 4) + CELL_SHIFT + 2;
   localparam int EW = $clog2(SCREEN_ROWS + 1);
   localparam int SW = (SHADE_LEVELS > 2) ? $clog2(SHADE_LEVELS) : 1;
   localparam logic signed [CW-1:0] MAP_LIM = CW'(MAP_DIM * (2 ** CELL_SHIFT));
   // column*fov/(COLUMNS-1) as a multiply by a rounded-up reciprocal
   localparam int RECIP_D = COLUMNS - 1;
   localparam int RECIP_S = 30 + $clog2(RECIP_D + 1);
   localparam logic [MUL_W-1:0] RECIP_M =
      MUL_W'(((64'd1 << RECIP_S) + 64'(RECIP_D) - 64'd1) / 64'(RECIP_D));

   typedef enum logic [16:0] {
      ST_IDLE      = 17'h00001,
      ST_ANGLE     = 17'h00002,
      ST_RAYTRIG   = 17'h00004,
      ST_STEPX     = 17'h00008,
      ST_STEPY     = 17'h00010,
      ST_LOOK      = 17'h00020,
      ST_CHECK     = 17'h00040,
      ST_SQX       = 17'h00080,
      ST_SQY       = 17'h00100,
      ST_ROOT      = 17'h00200,
      ST_CORTRIG   = 17'h00400,
      ST_CORR      = 17'h00800,
      ST_SHAPE     = 17'h01000,
      ST_DIVEND    = 17'h02000,
      ST_DIVSHADE  = 17'h04000,
      ST_DIVBRIGHT = 17'h08000,
      ST_EMIT      = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0]       fov_ff, fov_in;
   logic [7:0]        step_ff, step_in;
   logic [DIST_W-1:0] far_cfg_ff, far_cfg_in;
   logic [DIST_W-1:0] min_dist_ff, min_dist_in;

   // wall map
   logic [15:0]       map_mem [MAP_DIM];
   logic [MAP_DIM-1:0] map_vld_ff;
   logic [15:0]       rd_row_ff;
   logic              rd_vld_ff;

   // datapath
   logic [6:0]               col_ff, col_in;
   logic [ANG_W-1:0]         view_ff, view_in, ang_ff, ang_in;
   logic signed [CW-1:0]     x0_ff, x0_in, y0_ff, y0_in;
   logic signed [CW-1:0]     rx_ff, rx_in, ry_ff, ry_in;
   logic signed [CW-1:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic signed [TRIG_W-1:0] rs_ff, rs_in;
   logic [SQ_W-1:0]          sqx_ff, sqx_in;
   logic [DIST_W-1:0]        dist_ff, dist_in, far_ff, far_in;
   logic [EW-1:0]            end_ff, end_in;
   logic [SW-1:0]            shade_ff, shade_in;
   logic [7:0]               bright_ff, bright_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_col_ff, rsp_col_in;
   logic [12:0] rsp_dist_ff, rsp_dist_in;
   logic [4:0]  rsp_top_ff, rsp_top_in, rsp_end_ff, rsp_end_in;
   logic [3:0]  rsp_shade_ff, rsp_shade_in;
   logic [7:0]  rsp_bright_ff, rsp_bright_in;

   // shared units
   logic                     cor_start, mul_start, sq_start, div_start;
   logic [ANG_W-1:0]         cor_angle;
   logic [MUL_W-1:0]         mul_a, mul_b;
   logic [SQ_W-1:0]          sq_val;
   logic [DIV_NW-1:0]        div_num;
   logic [DIV_DW-1:0]        div_den;
   unit_stat_type            cor_stat, mul_stat, sq_stat, div_stat;
   logic signed [TRIG_W-1:0] cor_cos, cor_sin;
   logic [2*MUL_W-1:0]       mul_prod;
   logic [SQ_W/2-1:0]        sq_root;
   logic [DIV_NW-1:0]        div_quot;

   // combinational helpers
   logic                     accept, load_ok, emit_fire;
   logic [7:0]               step_eff;
   logic [RW-1:0]            cx, cy;
   logic                     oob, cx_ok, is_wall;
   logic signed [CW-1:0]     dx, dy;
   logic [CW-1:0]            ax, ay;
   logic [2*MUL_W-CORR_SHIFT-1:0] corr;
   logic [DIST_W-1:0]        corr_clip;
   logic [TRIG_W-1:0]        trig_mag;
   logic [EW:0]              top_full;

   grm_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .stat    (cor_stat),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   grm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .stat  (mul_stat),
      .prod  (mul_prod)
   );

   grm_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .val   (sq_val),
      .stat  (sq_stat),
      .root  (sq_root)
   );

   grm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_ok   = accept && (req_op == OP_LOAD) && (32'(req_map_row) < MAP_DIM);
   assign step_eff  = (step_ff == 8'd0) ? 8'd1 : step_ff;

   // wall test on the current ray point; map row was read in the look cycle
   assign cx      = rx_ff[CELL_SHIFT +: RW];
   assign cy      = ry_ff[CELL_SHIFT +: RW];
   assign oob     = rx_ff[CW-1] || ry_ff[CW-1] || (rx_ff >= MAP_LIM) || (ry_ff >= MAP_LIM);
   assign cx_ok   = 32'(cx) < 32'd16;
   assign is_wall = oob || (cx_ok && rd_vld_ff && rd_row_ff[4'(cx)]);

   assign dx = rx_ff - x0_ff;
   assign dy = ry_ff - y0_ff;
   assign ax = dx[CW-1] ? CW'(-dx) : CW'(dx);
   assign ay = dy[CW-1] ? CW'(-dy) : CW'(dy);

   assign corr      = mul_prod[2*MUL_W-1:CORR_SHIFT];
   assign corr_clip = (corr > (2*MUL_W-CORR_SHIFT)'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                                : corr[DIST_W-1:0];
   assign top_full  = ((EW+1)'(SCREEN_ROWS) - (EW+1)'(end_ff)) >> 1;
   assign emit_fire = (state_ff == ST_EMIT) && (state_in == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      fov_in      = fov_ff;
      step_in     = step_ff;
      far_cfg_in  = far_cfg_ff;
      min_dist_in = min_dist_ff;
      col_in      = col_ff;
      view_in     = view_ff;
      ang_in      = ang_ff;
      x0_in       = x0_ff;
      y0_in       = y0_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      rs_in       = rs_ff;
      sqx_in      = sqx_ff;
      dist_in     = dist_ff;
      far_in      = far_ff;
      end_in      = end_ff;
      shade_in    = shade_ff;
      bright_in   = bright_ff;
      cor_start   = 1'b0;
      cor_angle   = ang_ff;
      mul_start   = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      sq_start    = 1'b0;
      sq_val      = '0;
      div_start   = 1'b0;
      div_num     = '0;
      div_den     = '0;
      trig_mag    = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_col_in    = rsp_col_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_shade_in  = rsp_shade_ff;
      rsp_bright_in = rsp_bright_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_FOV:  fov_in      = csr_data;
            CSR_STEP: step_in     = csr_data[7:0];
            CSR_FAR:  far_cfg_in  = csr_data[DIST_W-1:0];
            CSR_MIN:  min_dist_in = csr_data[DIST_W-1:0];
            default:  fov_in      = fov_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_CAST)) begin
               col_in    = req_column;
               view_in   = req_view_angle;
               x0_in     = CW'(req_pos_x) <<< POS_SHIFT;
               y0_in     = CW'(req_pos_y) <<< POS_SHIFT;
               mul_start = 1'b1;
               mul_a     = MUL_W'(req_column) * MUL_W'(fov_ff);
               mul_b     = RECIP_M;
               state_in  = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            if (mul_stat.done) begin
               ang_in    = view_ff - (fov_ff >> 1) + mul_prod[RECIP_S +: ANG_W];
               cor_start = 1'b1;
               cor_angle = ang_in;
               state_in  = ST_RAYTRIG;
            end
         end
         ST_RAYTRIG: begin
            if (cor_stat.done) begin
               rs_in     = cor_sin;
               sx_in     = cor_cos[TRIG_W-1] ? CW'(1) : CW'(0);
               trig_mag  = cor_cos[TRIG_W-1] ? TRIG_W'(-cor_cos) : TRIG_W'(cor_cos);
               mul_start = 1'b1;
               mul_a     = MUL_W'(step_eff);
               mul_b     = MUL_W'(trig_mag);
               state_in  = ST_STEPX;
            end
         end
         ST_STEPX: begin
            // sx holds the cosine sign until the product lands
            if (mul_stat.done) begin
               sx_in     = sx_ff[0] ? CW'(-mul_prod[CW-1:0]) : CW'(mul_prod[CW-1:0]);
               trig_mag  = rs_ff[TRIG_W-1] ? TRIG_W'(-rs_ff) : TRIG_W'(rs_ff);
               mul_start = 1'b1;
               mul_a     = MUL_W'(step_eff);
               mul_b     = MUL_W'(trig_mag);
               state_in  = ST_STEPY;
            end
         end
         ST_STEPY: begin
            if (mul_stat.done) begin
               sy_in    = rs_ff[TRIG_W-1] ? CW'(-mul_prod[CW-1:0]) : CW'(mul_prod[CW-1:0]);
               rx_in    = x0_ff;
               ry_in    = y0_ff;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (is_wall) begin
               mul_start = 1'b1;
               mul_a     = MUL_W'(ax);
               mul_b     = MUL_W'(ax);
               state_in  = ST_SQX;
            end else begin
               rx_in    = rx_ff + sx_ff;
               ry_in    = ry_ff + sy_ff;
               state_in = ST_LOOK;
            end
         end
         ST_SQX: begin
            if (mul_stat.done) begin
               sqx_in    = mul_prod;
               mul_start = 1'b1;
               mul_a     = MUL_W'(ay);
               mul_b     = MUL_W'(ay);
               state_in  = ST_SQY;
            end
         end
         ST_SQY: begin
            if (mul_stat.done) begin
               sq_start = 1'b1;
               sq_val   = sqx_ff + mul_prod;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sq_stat.done) begin
               cor_start = 1'b1;
               cor_angle = ang_ff - view_ff;
               state_in  = ST_CORTRIG;
            end
         end
         ST_CORTRIG: begin
            if (cor_stat.done) begin
               if (cor_cos[TRIG_W-1] || (cor_cos == '0)) begin
                  // facing away from the heading: clamp straight to the floor
                  dist_in  = min_dist_ff;
                  state_in = ST_SHAPE;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = MUL_W'(sq_root);
                  mul_b     = MUL_W'(cor_cos);
                  state_in  = ST_CORR;
               end
            end
         end
         ST_CORR: begin
            if (mul_stat.done) begin
               dist_in  = (corr_clip < min_dist_ff) ? min_dist_ff : corr_clip;
               state_in = ST_SHAPE;
            end
         end
         ST_SHAPE: begin
            far_in = (far_cfg_ff == '0) ? DIST_W'(1) : far_cfg_ff;
            if (dist_ff < far_in) begin
               div_start = 1'b1;
               div_num   = DIV_NW'(dist_ff) * DIV_NW'(SCREEN_ROWS)
                         + DIV_NW'(far_in) - DIV_NW'(1);
               div_den   = DIV_DW'(far_in);
               state_in  = ST_DIVEND;
            end else begin
               end_in    = '0;
               shade_in  = '0;
               bright_in = '0;
               state_in  = ST_EMIT;
            end
         end
         ST_DIVEND: begin
            if (div_stat.done) begin
               end_in    = EW'(SCREEN_ROWS) - EW'(div_quot);
               div_start = 1'b1;
               div_num   = DIV_NW'(far_ff - dist_ff) * DIV_NW'(SHADE_LEVELS);
               div_den   = DIV_DW'(far_ff);
               state_in  = ST_DIVSHADE;
            end
         end
         ST_DIVSHADE: begin
            if (div_stat.done) begin
               shade_in  = (div_quot > DIV_NW'(SHADE_LEVELS - 1)) ? SW'(SHADE_LEVELS - 1)
                                                                  : SW'(div_quot);
               div_start = 1'b1;
               div_num   = DIV_NW'(far_ff - dist_ff) * DIV_NW'(255);
               div_den   = DIV_DW'(far_ff);
               state_in  = ST_DIVBRIGHT;
            end
         end
         ST_DIVBRIGHT: begin
            if (div_stat.done) begin
               bright_in = div_quot[7:0];
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_col_in    = col_ff;
               rsp_dist_in   = dist_ff;
               rsp_top_in    = 5'(top_full);
               rsp_end_in    = 5'(end_ff);
               rsp_shade_in  = 4'(shade_ff);
               rsp_bright_in = bright_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fov_ff       <= 16'd6144;
         step_ff      <= 8'd26;
         far_cfg_ff   <= 13'd3584;
         min_dist_ff  <= 13'd384;
         map_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fov_ff       <= fov_in;
         step_ff      <= step_in;
         far_cfg_ff   <= far_cfg_in;
         min_dist_ff  <= min_dist_in;
         if (load_ok)
            map_vld_ff[RW'(req_map_row)] <= 1'b1;
      end
   end

   // map row store with registered read
   always_ff @(posedge clock) begin
      if (load_ok)
         map_mem[RW'(req_map_row)] <= req_row_bits;
      if (state_ff == ST_LOOK) begin
         rd_row_ff <= map_mem[cy];
         rd_vld_ff <= map_vld_ff[cy];
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      view_ff       <= view_in;
      ang_ff        <= ang_in;
      x0_ff         <= x0_in;
      y0_ff         <= y0_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      rs_ff         <= rs_in;
      sqx_ff        <= sqx_in;
      dist_ff       <= dist_in;
      far_ff        <= far_in;
      end_ff        <= end_in;
      shade_ff      <= shade_in;
      bright_ff     <= bright_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_shade_ff  <= rsp_shade_in;
      rsp_bright_ff <= rsp_bright_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_column_out      = rsp_col_ff;
   assign rsp_wall_distance   = rsp_dist_ff;
   assign rsp_wall_top        = rsp_top_ff;
   assign rsp_wall_end        = rsp_end_ff;
   assign rsp_shade_index     = rsp_shade_ff;
   assign rsp_wall_brightness = rsp_bright_ff;

   `GRM_ASSERT_IMP(a_emit_slot_free, clock, reset, emit_fire, !rsp_valid_ff || rsp_ready)
   `GRM_ASSERT_IMP(a_dist_floor, clock, reset, rsp_valid_ff, rsp_wall_distance >= min_dist_ff)
   `GRM_ASSERT_NXT(a_march_advance, clock, reset, (state_ff == ST_CHECK) && !is_wall, state_ff == ST_LOOK)

endmodule
